[rtl/abcs_pkg.sv]
package abcs_pkg;

  localparam int unsigned BOXES_DEF     = 64;
  localparam int unsigned FRAC_BITS_DEF = 8;

  // Configuration register indexes
  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_WIN_W   = 2'd1;
  localparam logic [1:0] REG_WIN_H   = 2'd2;

  localparam logic SOLVE_X = 1'b0;
  localparam logic SOLVE_Y = 1'b1;

  // Body state as it travels down the cell row
  typedef struct packed {
    logic               valid;
    logic               phase;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic        [22:0] w;
    logic        [22:0] h;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic               ground;
  } body_t;

  // Box table write, broadcast to every cell
  typedef struct packed {
    logic               en;
    logic        [5:0]  slot;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic        [22:0] w;
    logic        [22:0] h;
    logic               solid;
  } box_wr_t;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -26'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

  function automatic logic signed [25:0] sx26(input logic signed [23:0] v);
    return {{2{v[23]}}, v};
  endfunction

  function automatic logic signed [25:0] ux26(input logic [22:0] v);
    return $signed({3'b000, v});
  endfunction

endpackage

[rtl/abcs_cell.sv]
module abcs_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  abcs_pkg::box_wr_t wr,
  input  abcs_pkg::body_t  bin,
  output abcs_pkg::body_t  bout
);

  logic               live;
  logic signed [23:0] box_x;
  logic signed [23:0] box_y;
  logic        [22:0] box_w;
  logic        [22:0] box_h;
  logic               sel;

  logic signed [25:0] x0, x1, y0, y1, bx0, bx1, by0, by1;
  logic               hit;
  abcs_pkg::body_t    nb;

  assign sel = wr.en && ({26'd0, wr.slot} == 32'(IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (sel) begin
      live <= wr.solid;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      box_x <= wr.x;
      box_y <= wr.y;
      box_w <= wr.w;
      box_h <= wr.h;
    end
  end

  always_comb begin
    x0  = abcs_pkg::sx26(bin.x);
    x1  = x0 + abcs_pkg::ux26(bin.w);
    y0  = abcs_pkg::sx26(bin.y);
    y1  = y0 + abcs_pkg::ux26(bin.h);
    bx0 = abcs_pkg::sx26(box_x);
    bx1 = bx0 + abcs_pkg::ux26(box_w);
    by0 = abcs_pkg::sx26(box_y);
    by1 = by0 + abcs_pkg::ux26(box_h);
    hit = live && (x0 < bx1) && (x1 > bx0) && (y0 < by1) && (y1 > by0);
    nb  = bin;
    if (hit) begin
      if (bin.phase == abcs_pkg::SOLVE_X) begin
        if (bin.vx > 24'sd0) begin
          nb.x  = abcs_pkg::sat24(bx0 - abcs_pkg::ux26(bin.w));
          nb.vx = '0;
        end else if (bin.vx < 24'sd0) begin
          nb.x  = abcs_pkg::sat24(bx1);
          nb.vx = '0;
        end
      end else begin
        if (bin.vy > 24'sd0) begin
          nb.y      = abcs_pkg::sat24(by0 - abcs_pkg::ux26(bin.h));
          nb.vy     = '0;
          nb.ground = 1'b1;
        end else begin
          nb.y  = abcs_pkg::sat24(by1);
          nb.vy = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bout.valid <= 1'b0;
    end else begin
      bout.valid <= bin.valid;
    end
  end

  always_ff @(posedge clk) begin
    bout.phase  <= nb.phase;
    bout.x      <= nb.x;
    bout.y      <= nb.y;
    bout.w      <= nb.w;
    bout.h      <= nb.h;
    bout.vx     <= nb.vx;
    bout.vy     <= nb.vy;
    bout.ground <= nb.ground;
  end

endmodule

[rtl/aabb_body_collision_step_unit.sv]
// Channel   | Signals                                         | Handshake
// ----------+-------------------------------------------------+------------------------------
// command   | mode slot pos_x pos_y size_w size_h solid ...   | beat taken when start & !busy
// result    | new_x new_y new_vx new_vy on_ground             | one-cycle done strobe
// config    | cfg_wr cfg_addr cfg_wdata                       | written when cfg_wr is high
//
// A box write (mode 0) is registered into its cell and leaves busy low.
// A body step (mode 1) runs from accept to done through multiply, add and clamp
// steps; the body walks the row of BOXES box cells once for the x solve and once
// for the y solve, one cell per cycle.
// Reset (rst, synchronous) clears all solid flags and loads the register defaults.
// The receiver cannot stall: a result shows for exactly one cycle with done.
module aabb_body_collision_step_unit #(
  parameter int unsigned BOXES     = abcs_pkg::BOXES_DEF,
  parameter int unsigned FRAC_BITS = abcs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic        [5:0]  slot,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic        [22:0] size_w,
  input  logic        [22:0] size_h,
  input  logic               solid,
  input  logic signed [23:0] vel_x,
  input  logic signed [23:0] vel_y,
  input  logic        [15:0] dt,
  input  logic               cfg_wr,
  input  logic        [1:0]  cfg_addr,
  input  logic        [23:0] cfg_wdata,
  output logic               done,
  output logic signed [23:0] new_x,
  output logic signed [23:0] new_y,
  output logic signed [23:0] new_vx,
  output logic signed [23:0] new_vy,
  output logic               on_ground
);

  // Window defaults: 800 x 600 pixels, scaled and saturated to 23 bits
  localparam longint WW_RAW = 64'sd800 << FRAC_BITS;
  localparam longint WH_RAW = 64'sd600 << FRAC_BITS;
  localparam logic [22:0] WIN_W_RST = (WW_RAW > 64'sd8388607) ? 23'h7FFFFF : 23'(WW_RAW);
  localparam logic [22:0] WIN_H_RST = (WH_RAW > 64'sd8388607) ? 23'h7FFFFF : 23'(WH_RAW);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_ADD1, S_XWAIT, S_MUL2, S_ADD2, S_YWAIT, S_CLAMP
  } state_t;

  state_t             state;
  logic signed [23:0] gravity;
  logic        [22:0] win_w;
  logic        [22:0] win_h;
  logic        [15:0] dt_r;
  logic signed [40:0] prod_a;
  logic signed [40:0] prod_b;
  abcs_pkg::body_t    bod;
  abcs_pkg::body_t    inj;
  abcs_pkg::box_wr_t  wr;
  abcs_pkg::body_t    link [BOXES+1];

  logic               accept;
  logic signed [25:0] step_a, step_b;
  logic signed [23:0] cx, cy, cvx, cvy;
  logic               cg;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= '0;
      win_w   <= WIN_W_RST;
      win_h   <= WIN_H_RST;
    end else if (cfg_wr) begin
      case (cfg_addr)
        abcs_pkg::REG_GRAVITY: gravity <= $signed(cfg_wdata);
        abcs_pkg::REG_WIN_W:   win_w   <= cfg_wdata[22:0];
        abcs_pkg::REG_WIN_H:   win_h   <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  // Box writes go straight to the cells
  always_comb begin
    wr.en    = accept && !mode;
    wr.slot  = slot;
    wr.x     = pos_x;
    wr.y     = pos_y;
    wr.w     = size_w;
    wr.h     = size_h;
    wr.solid = solid;
  end

  assign link[0] = inj;

  for (genvar g = 0; g < BOXES; g++) begin : g_cell
    abcs_cell #(.IDX(g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .wr   (wr),
      .bin  (link[g]),
      .bout (link[g+1])
    );
  end

  // Floor shift of value*dt by 16, sign-extended for the add
  assign step_a = {prod_a[40], prod_a[40:16]};
  assign step_b = {prod_b[40], prod_b[40:16]};

  // Window clamp: left, right, top, then floor
  always_comb begin
    cx  = bod.x;
    cy  = bod.y;
    cvx = bod.vx;
    cvy = bod.vy;
    cg  = bod.ground;
    if (cx < 24'sd0) begin
      cx  = '0;
      cvx = '0;
    end
    if (abcs_pkg::sx26(cx) + abcs_pkg::ux26(bod.w) > abcs_pkg::ux26(win_w)) begin
      cx  = abcs_pkg::sat24(abcs_pkg::ux26(win_w) - abcs_pkg::ux26(bod.w));
      cvx = '0;
    end
    if (cy < 24'sd0) begin
      cy  = '0;
      cvy = '0;
    end
    if (abcs_pkg::sx26(cy) + abcs_pkg::ux26(bod.h) > abcs_pkg::ux26(win_h)) begin
      cy  = abcs_pkg::sat24(abcs_pkg::ux26(win_h) - abcs_pkg::ux26(bod.h));
      cvy = '0;
      cg  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inj.valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      inj.valid <= 1'b0;
      done      <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && mode) begin
            bod.x      <= pos_x;
            bod.y      <= pos_y;
            bod.w      <= size_w;
            bod.h      <= size_h;
            bod.vx     <= vel_x;
            bod.vy     <= vel_y;
            bod.ground <= 1'b0;
            bod.phase  <= abcs_pkg::SOLVE_X;
            dt_r       <= dt;
            state      <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod_a <= gravity * $signed({1'b0, dt_r});
          prod_b <= bod.vx * $signed({1'b0, dt_r});
          state  <= S_ADD1;
        end
        S_ADD1: begin
          // Apply gravity, move x, send the body down the row for the x solve
          inj.valid  <= 1'b1;
          inj.phase  <= abcs_pkg::SOLVE_X;
          inj.x      <= abcs_pkg::sat24(abcs_pkg::sx26(bod.x) + step_b);
          inj.y      <= bod.y;
          inj.w      <= bod.w;
          inj.h      <= bod.h;
          inj.vx     <= bod.vx;
          inj.vy     <= abcs_pkg::sat24(abcs_pkg::sx26(bod.vy) + step_a);
          inj.ground <= 1'b0;
          state      <= S_XWAIT;
        end
        S_XWAIT: begin
          if (link[BOXES].valid) begin
            bod   <= link[BOXES];
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          prod_b <= bod.vy * $signed({1'b0, dt_r});
          state  <= S_ADD2;
        end
        S_ADD2: begin
          inj.valid  <= 1'b1;
          inj.phase  <= abcs_pkg::SOLVE_Y;
          inj.x      <= bod.x;
          inj.y      <= abcs_pkg::sat24(abcs_pkg::sx26(bod.y) + step_b);
          inj.w      <= bod.w;
          inj.h      <= bod.h;
          inj.vx     <= bod.vx;
          inj.vy     <= bod.vy;
          inj.ground <= bod.ground;
          state      <= S_YWAIT;
        end
        S_YWAIT: begin
          if (link[BOXES].valid) begin
            bod   <= link[BOXES];
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          new_x     <= cx;
          new_y     <= cy;
          new_vx    <= cvx;
          new_vy    <= cvy;
          on_ground <= cg;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result only ends a step that was under way
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a step in flight");

  // The body leaves the row only while the sequencer waits for it
  a_row_exit: assert property (@(posedge clk) disable iff (rst)
    link[BOXES].valid |-> (state == S_XWAIT || state == S_YWAIT))
    else $error("body left the cell row unexpectedly");

  // A step begins only on an accepted body command
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && mode))
    else $error("busy rose without a body command");

  // The row carries nothing while idle
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !inj.valid)
    else $error("injection while idle");

endmodule

[test/tb_aabb_body_collision_step_unit.sv]
module tb_aabb_body_collision_step_unit;

  // Spare register index: the block must ignore writes to it.
  localparam logic [1:0] REG_NONE = 2'd3;
  // Quiet cycles before a register write: a box write makes no result, so
  // cover a full body step plus margin after the last result.
  localparam int QUIET_CYCLES = 2 * abcs_pkg::BOXES_DEF + 20;
  localparam int PX = 256;  // one pixel in Q16.8

  typedef enum logic [1:0] {OP_BOX, OP_BODY, OP_CFG} op_e;

  typedef struct {
    op_e                kind;
    logic               mode;
    logic        [5:0]  slot;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic        [22:0] size_w;
    logic        [22:0] size_h;
    logic               solid;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic        [15:0] dt;
    logic        [1:0]  addr;
    logic        [23:0] wdata;
  } beat_t;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic               ground;
  } step_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               start = 1'b0;
  logic               mode = 1'b0;
  logic        [5:0]  slot = '0;
  logic signed [23:0] pos_x = '0;
  logic signed [23:0] pos_y = '0;
  logic        [22:0] size_w = '0;
  logic        [22:0] size_h = '0;
  logic               solid = 1'b0;
  logic signed [23:0] vel_x = '0;
  logic signed [23:0] vel_y = '0;
  logic        [15:0] dt = '0;
  logic               cfg_wr = 1'b0;
  logic        [1:0]  cfg_addr = '0;
  logic        [23:0] cfg_wdata = '0;
  logic               busy;
  logic               done;
  logic signed [23:0] new_x;
  logic signed [23:0] new_y;
  logic signed [23:0] new_vx;
  logic signed [23:0] new_vy;
  logic               on_ground;

  aabb_body_collision_step_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .slot(slot), .pos_x(pos_x), .pos_y(pos_y),
    .size_w(size_w), .size_h(size_h), .solid(solid),
    .vel_x(vel_x), .vel_y(vel_y), .dt(dt),
    .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .done(done), .new_x(new_x), .new_y(new_y), .new_vx(new_vx),
    .new_vy(new_vy), .on_ground(on_ground)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow of the box table and the registers, updated as beats are taken.
  longint shadow_bx [abcs_pkg::BOXES_DEF];
  longint shadow_by [abcs_pkg::BOXES_DEF];
  longint shadow_bw [abcs_pkg::BOXES_DEF];
  longint shadow_bh [abcs_pkg::BOXES_DEF];
  bit     shadow_live [abcs_pkg::BOXES_DEF];
  longint grav_q;
  longint win_w_q;
  longint win_h_q;

  beat_t     pending_beats[$];
  step_out_t expected_steps[$];
  int        mismatch_cnt = 0;
  int        steps_seen = 0;
  int        boxes_sent = 0;
  int        cfg_sent = 0;
  int        ground_seen = 0;

  function automatic longint clip24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // value * dt in Q0.16, floored
  function automatic longint times_dt(longint v, longint d);
    return (v * d) >>> 16;
  endfunction

  function automatic bit overlaps(longint x, longint y, longint w, longint h, int i);
    return x < shadow_bx[i] + shadow_bw[i] && x + w > shadow_bx[i] &&
           y < shadow_by[i] + shadow_bh[i] && y + h > shadow_by[i];
  endfunction

  function automatic step_out_t resolve_body(beat_t b);
    longint    x, y, w, h, vx, vy, d;
    bit        gnd;
    step_out_t r;
    x = longint'(b.pos_x);
    y = longint'(b.pos_y);
    w = longint'(b.size_w);
    h = longint'(b.size_h);
    vx = longint'(b.vel_x);
    vy = longint'(b.vel_y);
    d = longint'(b.dt);
    gnd = 1'b0;
    vy = clip24(vy + times_dt(grav_q, d));
    x = clip24(x + times_dt(vx, d));
    for (int i = 0; i < abcs_pkg::BOXES_DEF; i++) begin
      if (!shadow_live[i] || !overlaps(x, y, w, h, i)) continue;
      if (x + w > shadow_bx[i] && vx > 0) begin
        x = clip24(shadow_bx[i] - w);
        vx = 0;
      end else if (x < shadow_bx[i] + shadow_bw[i] && vx < 0) begin
        x = clip24(shadow_bx[i] + shadow_bw[i]);
        vx = 0;
      end
    end
    y = clip24(y + times_dt(vy, d));
    for (int i = 0; i < abcs_pkg::BOXES_DEF; i++) begin
      if (!shadow_live[i] || !overlaps(x, y, w, h, i)) continue;
      if (y + h > shadow_by[i] && vy > 0) begin
        y = clip24(shadow_by[i] - h);
        vy = 0;
        gnd = 1'b1;
      end else if (y < shadow_by[i] + shadow_bh[i] && vy <= 0) begin
        // resting body (vy zero) is pushed down to the box bottom
        y = clip24(shadow_by[i] + shadow_bh[i]);
        vy = 0;
      end
    end
    if (x < 0) begin
      x = 0;
      vx = 0;
    end
    if (x + w > win_w_q) begin
      x = clip24(win_w_q - w);
      vx = 0;
    end
    if (y < 0) begin
      y = 0;
      vy = 0;
    end
    if (y + h > win_h_q) begin
      y = clip24(win_h_q - h);
      gnd = 1'b1;
      vy = 0;
    end
    r.x = x[23:0];
    r.y = y[23:0];
    r.vx = vx[23:0];
    r.vy = vy[23:0];
    r.ground = gnd;
    return r;
  endfunction

  // Apply one taken command beat to the shadow state.
  function automatic void absorb_beat(beat_t b);
    int s;
    if (b.mode == 1'b0) begin
      s = b.slot;
      shadow_bx[s] = longint'(b.pos_x);
      shadow_by[s] = longint'(b.pos_y);
      shadow_bw[s] = longint'(b.size_w);
      shadow_bh[s] = longint'(b.size_h);
      shadow_live[s] = b.solid;
    end else begin
      expected_steps.push_back(resolve_body(b));
    end
  endfunction

  function automatic void absorb_cfg(logic [1:0] a, logic [23:0] v);
    case (a)
      abcs_pkg::REG_GRAVITY: grav_q = longint'($signed(v));
      abcs_pkg::REG_WIN_W: win_w_q = longint'(v[22:0]);
      abcs_pkg::REG_WIN_H: win_h_q = longint'(v[22:0]);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_cfg(logic [1:0] a, int v);
    beat_t b;
    b = '{kind: OP_CFG, default: '0};
    b.addr = a;
    b.wdata = 24'(v);
    pending_beats.push_back(b);
  endtask

  task automatic add_box(int s, int x, int y, int w, int h, bit sol);
    beat_t b;
    b = '{kind: OP_BOX, default: '0};
    b.mode = 1'b0;
    b.slot = 6'(s);
    b.pos_x = 24'(x);
    b.pos_y = 24'(y);
    b.size_w = 23'(w);
    b.size_h = 23'(h);
    b.solid = sol;
    b.vel_x = 24'($urandom);  // ignored by a box write
    b.vel_y = 24'($urandom);
    b.dt = 16'($urandom);
    pending_beats.push_back(b);
  endtask

  task automatic add_body(int x, int y, int w, int h, int vx, int vy, int d);
    beat_t b;
    b = '{kind: OP_BODY, default: '0};
    b.mode = 1'b1;
    b.slot = 6'($urandom);  // ignored by a body step
    b.solid = 1'($urandom);
    b.pos_x = 24'(x);
    b.pos_y = 24'(y);
    b.size_w = 23'(w);
    b.size_h = 23'(h);
    b.vel_x = 24'(vx);
    b.vel_y = 24'(vy);
    b.dt = 16'(d);
    pending_beats.push_back(b);
  endtask

  task automatic add_noise();
    beat_t b;
    b.kind = OP_BOX;
    b.mode = 1'($urandom);
    if (b.mode) b.kind = OP_BODY;
    b.slot = 6'($urandom);
    b.pos_x = 24'($urandom);
    b.pos_y = 24'($urandom);
    b.size_w = 23'($urandom);
    b.size_h = 23'($urandom);
    b.solid = 1'($urandom);
    b.vel_x = 24'($urandom);
    b.vel_y = 24'($urandom);
    b.dt = 16'($urandom);
    b.addr = '0;
    b.wdata = '0;
    pending_beats.push_back(b);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  int beats_left;

  initial begin
    int items, nbox, bx, by;
    // directed: a small level under moderate gravity
    add_cfg(abcs_pkg::REG_GRAVITY, 500 * PX);
    add_box(0, 100 * PX, 400 * PX, 200 * PX, 20 * PX, 1'b1);  // platform
    add_box(1, 400 * PX, 0, 20 * PX, 600 * PX, 1'b1);         // wall
    add_box(2, 50 * PX, 50 * PX, 40 * PX, 40 * PX, 1'b0);     // ghost box
    add_box(3, 100 * PX, 390 * PX, 200 * PX, 20 * PX, 1'b1);  // second slab
    add_box(63, 600 * PX, 300 * PX, 50 * PX, 50 * PX, 1'b1);
    add_body(360 * PX, 100 * PX, 32 * PX, 32 * PX, 100 * PX, 0, 16'h8000);
    add_body(430 * PX, 100 * PX, 32 * PX, 32 * PX, -100 * PX, 0, 16'h8000);
    add_body(150 * PX, 340 * PX, 32 * PX, 32 * PX, 0, 100 * PX, 16'h8000);
    add_body(150 * PX, 430 * PX, 32 * PX, 32 * PX, 0, -300 * PX, 16'h8000);
    add_body(560 * PX, 280 * PX, 32 * PX, 32 * PX, 200 * PX, 60 * PX, 16'h4000);
    add_body(55 * PX, 55 * PX, 16 * PX, 16 * PX, 10 * PX, 0, 16'h1000);
    add_body(500 * PX, 590 * PX, 32 * PX, 32 * PX, 0, 50 * PX, 16'h8000);
    add_body(-10 * PX, -10 * PX, 32 * PX, 32 * PX, 0, 0, 0);
    add_body(24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
             16'hFFFF);
    add_body(24'h800000, 24'h800000, 0, 0, 24'h800000, 24'h800000, 16'hFFFF);
    add_body(100 * PX, 0, 0, 23'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h0001);
    add_cfg(abcs_pkg::REG_WIN_W, 16 * PX);  // narrower than the body
    add_cfg(abcs_pkg::REG_GRAVITY, 24'h800000);
    add_body(0, 0, 32 * PX, 32 * PX, 5 * PX, 0, 16'hFFFF);
    add_cfg(REG_NONE, 24'hFFFFFF);
    add_cfg(abcs_pkg::REG_WIN_W, 24'hFFFFFF);
    add_cfg(abcs_pkg::REG_WIN_H, 1);
    add_cfg(abcs_pkg::REG_GRAVITY, 24'h7FFFFF);
    add_body(7 * PX, 7 * PX, 2 * PX, 2 * PX, 0, 0, 16'hFFFF);
    items = 25;

    // random phases: registers, a small level, then bodies dropped into it
    while (items < 1000) begin
      case ($urandom_range(0, 5))
        0: add_cfg(abcs_pkg::REG_GRAVITY, 24'h800000);
        1: add_cfg(abcs_pkg::REG_GRAVITY, 24'h7FFFFF);
        2: add_cfg(abcs_pkg::REG_GRAVITY, $urandom);
        default: add_cfg(abcs_pkg::REG_GRAVITY, $urandom_range(0, 2000 * PX));
      endcase
      case ($urandom_range(0, 5))
        0: add_cfg(abcs_pkg::REG_WIN_W, 1);
        1: add_cfg(abcs_pkg::REG_WIN_W, 23'h7FFFFF);
        default: add_cfg(abcs_pkg::REG_WIN_W, $urandom_range(200 * PX, 1000 * PX));
      endcase
      case ($urandom_range(0, 5))
        0: add_cfg(abcs_pkg::REG_WIN_H, 1);
        1: add_cfg(abcs_pkg::REG_WIN_H, 23'h7FFFFF);
        default: add_cfg(abcs_pkg::REG_WIN_H, $urandom_range(200 * PX, 800 * PX));
      endcase
      if ($urandom_range(0, 3) == 0) add_cfg(REG_NONE, $urandom);
      nbox = $urandom_range(2, 12);
      for (int k = 0; k < nbox; k++) begin
        add_box($urandom_range(0, 63), $urandom_range(0, 600 * PX),
                $urandom_range(0, 500 * PX), $urandom_range(0, 200 * PX),
                $urandom_range(0, 60 * PX), $urandom_range(0, 3) != 0);
        items++;
      end
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 99) < 15) begin
          add_noise();
        end else begin
          bx = $urandom_range(0, 700 * PX);
          by = $urandom_range(0, 600 * PX);
          add_body(bx - 50 * PX, by - 50 * PX, $urandom_range(0, 64 * PX),
                   $urandom_range(0, 64 * PX), $urandom_range(0, 1200 * PX) - 600 * PX,
                   $urandom_range(0, 1200 * PX) - 600 * PX, $urandom_range(0, 16'hFFFF));
        end
        items++;
      end
    end
    beats_left = pending_beats.size();
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer command beats with random gaps, write registers when idle
  // ---------------------------------------------------------------------------
  beat_t cur_beat;
  int    gap_left = 0;
  int    quiet_cnt = 0;

  always @(posedge clk) begin
    logic  n_start, n_wr, taken;
    beat_t nb;
    n_start = start;
    n_wr = 1'b0;
    taken = start && !busy;
    if (rst) begin
      n_start = 1'b0;
      quiet_cnt = 0;
    end else begin
      if (taken) begin
        absorb_beat(cur_beat);
        n_start = 1'b0;
      end
      // count idle cycles with nothing in flight
      if (!start && !busy && expected_steps.size() == 0) quiet_cnt++;
      else quiet_cnt = 0;
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_beats.size() > 0) begin
          nb = pending_beats[0];
          if (nb.kind == OP_CFG) begin
            // hold register writes until the block has drained
            if (!taken && quiet_cnt >= QUIET_CYCLES) begin
              void'(pending_beats.pop_front());
              absorb_cfg(nb.addr, nb.wdata);
              cfg_addr <= nb.addr;
              cfg_wdata <= nb.wdata;
              n_wr = 1'b1;
              cfg_sent++;
              quiet_cnt = 0;
            end
          end else begin
            void'(pending_beats.pop_front());
            cur_beat = nb;
            mode <= nb.mode;
            slot <= nb.slot;
            pos_x <= nb.pos_x;
            pos_y <= nb.pos_y;
            size_w <= nb.size_w;
            size_h <= nb.size_h;
            solid <= nb.solid;
            vel_x <= nb.vel_x;
            vel_y <= nb.vel_y;
            dt <= nb.dt;
            if (nb.mode == 1'b0) boxes_sent++;
            n_start = 1'b1;
            gap_left = pick_gap();
          end
        end
      end
    end
    start <= n_start;
    cfg_wr <= n_wr;
  end

  // ---------------------------------------------------------------------------
  // Monitor: each done strobe is one result beat, checked against the oldest
  // predicted step
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    step_out_t e;
    if (!rst && done) begin
      steps_seen++;
      if (on_ground) ground_seen++;
      if (expected_steps.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: x=%0d y=%0d vx=%0d vy=%0d g=%0b",
                   new_x, new_y, new_vx, new_vy, on_ground);
      end else begin
        e = expected_steps.pop_front();
        if (new_x !== e.x || new_y !== e.y || new_vx !== e.vx ||
            new_vy !== e.vy || on_ground !== e.ground) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"step %0d mismatch: exp x=%0d y=%0d vx=%0d vy=%0d g=%0b, ",
                      "got x=%0d y=%0d vx=%0d vy=%0d g=%0b"},
                     steps_seen, e.x, e.y, e.vx, e.vy, e.ground,
                     new_x, new_y, new_vx, new_vy, on_ground);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // End of run: drain, let the block settle, then report
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < abcs_pkg::BOXES_DEF; i++) begin
      shadow_bx[i] = 0;
      shadow_by[i] = 0;
      shadow_bw[i] = 0;
      shadow_bh[i] = 0;
      shadow_live[i] = 1'b0;
    end
    grav_q = 0;
    win_w_q = 800 * PX;
    win_h_q = 600 * PX;
    @(negedge rst);
    wait (pending_beats.size() == 0 && !start && expected_steps.size() == 0);
    repeat (2 * abcs_pkg::BOXES_DEF + 20) @(posedge clk);
    if (expected_steps.size() != 0) mismatch_cnt += expected_steps.size();
    $display("covered %0d body steps (%0d landed), %0d box writes, %0d register writes",
             steps_seen, ground_seen, boxes_sent, cfg_sent);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("timeout waiting for results");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/abcs_pkg.sv
rtl/abcs_cell.sv
rtl/aabb_body_collision_step_unit.sv
test/tb_aabb_body_collision_step_unit.sv
